// ===== src/bffr_pkg.sv =====
// ----------------------------------------------------------------------------
// bffr_pkg: shared constants and types for the free-run search unit
// Map geometry, word packing of the bitmap, item kinds and the control
// structs passed between the sequencer and the scan pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bffr_pkg;

   // map geometry
   localparam int ROWS      = 8;
   localparam int SLOTS     = 1024;
   localparam int ROW_W     = 3;
   localparam int SLOT_W    = 10;

   // one memory word holds 64 slots of one row
   localparam int WORD_BITS     = 64;
   localparam int BIT_W         = $clog2(WORD_BITS);
   localparam int WORDS_PER_ROW = SLOTS / WORD_BITS;
   localparam int WIDX_W        = $clog2(WORDS_PER_ROW);
   localparam int WORDS         = ROWS * WORDS_PER_ROW;
   localparam int ADDR_W        = ROW_W + WIDX_W;

   // run length register and run counters
   localparam int CNT_W = SLOT_W + 1;
   localparam logic [CNT_W-1:0] RUN_LEN_RESET = CNT_W'(60);
   localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);

   // item kinds
   localparam logic [1:0] KIND_MARK   = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // one word entering the scan pipeline
   typedef struct packed {
      logic              vld;
      logic              last;
      logic [ROW_W-1:0]  row;
      logic [WIDX_W-1:0] widx;
   } scan_in_type;

   // scan outcome
   typedef struct packed {
      logic              done;
      logic              found;
      logic [ROW_W-1:0]  run_row;
      logic [SLOT_W-1:0] run_start;
      logic [SLOT_W-1:0] run_end;
   } scan_res_type;

endpackage

`default_nettype wire

// ===== src/bffr_map_ram.sv =====
// ----------------------------------------------------------------------------
// bffr_map_ram: occupancy bitmap storage
// One-port-read, one-port-write word memory with registered read data and a
// valid bit per word; a word that is not valid reads as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module bffr_map_ram (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clear_all,
   input  wire logic                              rd_en,
   input  wire logic [bffr_pkg::ADDR_W-1:0]       rd_addr,
   output logic      [bffr_pkg::WORD_BITS-1:0]    rd_data,
   input  wire logic                              wr_en,
   input  wire logic [bffr_pkg::ADDR_W-1:0]       wr_addr,
   input  wire logic [bffr_pkg::WORD_BITS-1:0]    wr_data
);

   logic [bffr_pkg::WORD_BITS-1:0] mem [0:bffr_pkg::WORDS-1];
   logic [bffr_pkg::WORDS-1:0]     vld_ff;
   logic                           rd_vld_ff;
   logic [bffr_pkg::WORD_BITS-1:0] rd_q_ff;

   // valid bits: cleared at once by reset or a clear item
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff   <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '1;

endmodule

`default_nettype wire

// ===== src/bffr_scan.sv =====
// ----------------------------------------------------------------------------
// bffr_scan: free-run scan pipeline
// Takes one bitmap word a cycle, tracks the free run carried across words of
// a row and reports the first slot at which the run reaches the length.
// ----------------------------------------------------------------------------
`default_nettype none

module bffr_scan (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           flush,
   input  wire bffr_pkg::scan_in_type          scan_in,
   input  wire logic [bffr_pkg::WORD_BITS-1:0] word,
   input  wire logic [bffr_pkg::CNT_W-1:0]     need,
   output bffr_pkg::scan_res_type              res
);

   localparam int NB = bffr_pkg::WORD_BITS;

   // prefix scan results
   logic [NB-1:0]                has_lvl [0:bffr_pkg::BIT_W];
   logic [bffr_pkg::BIT_W-1:0]   pos_lvl [0:bffr_pkg::BIT_W][0:NB-1];
   logic [bffr_pkg::CNT_W-1:0]   cnt_before;
   logic [bffr_pkg::CNT_W-1:0]   cnt_in;

   // carried run count
   logic [bffr_pkg::CNT_W-1:0]   cnt_ff;

   // stage B registers
   logic                         b_vld_ff;
   logic                         b_last_ff;
   logic [bffr_pkg::ROW_W-1:0]   b_row_ff;
   logic [bffr_pkg::WIDX_W-1:0]  b_widx_ff;
   logic [NB-1:0]                b_has_ff;
   logic [bffr_pkg::BIT_W-1:0]   b_pos_ff [0:NB-1];
   logic [bffr_pkg::CNT_W-1:0]   b_cnt_ff;

   // stage C registers
   logic                         c_vld_ff;
   logic                         c_last_ff;
   logic [bffr_pkg::ROW_W-1:0]   c_row_ff;
   logic [bffr_pkg::WIDX_W-1:0]  c_widx_ff;
   logic [NB-1:0]                c_hit_ff;

   logic [NB-1:0]                hit_in;
   logic [NB-1:0]                iso;
   logic [bffr_pkg::BIT_W-1:0]   hit_idx;
   logic [bffr_pkg::SLOT_W-1:0]  end_slot;

   // last busy bit at or below each position: log-depth prefix scan
   always_comb begin
      has_lvl[0] = ~word;
      for (int j = 0; j < NB; j++) begin
         pos_lvl[0][j] = bffr_pkg::BIT_W'(j);
      end
      for (int k = 0; k < bffr_pkg::BIT_W; k++) begin
         for (int j = 0; j < NB; j++) begin
            if (j >= (1 << k) && !has_lvl[k][j]) begin
               has_lvl[k+1][j] = has_lvl[k][j - (1 << k)];
               pos_lvl[k+1][j] = pos_lvl[k][j - (1 << k)];
            end else begin
               has_lvl[k+1][j] = has_lvl[k][j];
               pos_lvl[k+1][j] = pos_lvl[k][j];
            end
         end
      end
   end

   // free run carried into this word and out of it
   always_comb begin
      cnt_before = (scan_in.widx == '0) ? '0 : cnt_ff;
      if (has_lvl[bffr_pkg::BIT_W][NB-1]) begin
         cnt_in = bffr_pkg::CNT_W'(NB - 1)
                  - bffr_pkg::CNT_W'(pos_lvl[bffr_pkg::BIT_W][NB-1]);
      end else begin
         cnt_in = cnt_before + bffr_pkg::CNT_W'(NB);
      end
   end

   // stage C: run length ending at each bit against the needed length
   always_comb begin
      logic [bffr_pkg::CNT_W-1:0] len;
      for (int j = 0; j < NB; j++) begin
         if (b_has_ff[j]) begin
            len = bffr_pkg::CNT_W'(bffr_pkg::BIT_W'(j) - b_pos_ff[j]);
         end else begin
            len = b_cnt_ff + bffr_pkg::CNT_W'(j) + bffr_pkg::CNT_W'(1);
         end
         hit_in[j] = (len >= need);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= scan_in.vld && !flush;
         c_vld_ff <= b_vld_ff && !flush;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (scan_in.vld) begin
         cnt_ff <= cnt_in;
      end
      b_last_ff <= scan_in.last;
      b_row_ff  <= scan_in.row;
      b_widx_ff <= scan_in.widx;
      b_has_ff  <= has_lvl[bffr_pkg::BIT_W];
      b_pos_ff  <= pos_lvl[bffr_pkg::BIT_W];
      b_cnt_ff  <= cnt_before;
      c_last_ff <= b_last_ff;
      c_row_ff  <= b_row_ff;
      c_widx_ff <= b_widx_ff;
      c_hit_ff  <= hit_in;
   end

   // stage D: lowest hit and the run it closes
   always_comb begin
      iso     = c_hit_ff & (~c_hit_ff + NB'(1));
      hit_idx = '0;
      for (int j = 0; j < NB; j++) begin
         if (iso[j]) begin
            hit_idx = hit_idx | bffr_pkg::BIT_W'(j);
         end
      end
      end_slot = {c_widx_ff, hit_idx};
      res.found = |c_hit_ff;
      res.done  = c_vld_ff && (res.found || c_last_ff);
      if (res.found) begin
         res.run_row   = c_row_ff;
         res.run_end   = end_slot;
         res.run_start = bffr_pkg::SLOT_W'(({1'b0, end_slot} + bffr_pkg::CNT_W'(1)) - need);
      end else begin
         res.run_row   = '0;
         res.run_end   = '0;
         res.run_start = '0;
      end
   end

endmodule

`default_nettype wire

// ===== src/bitmap_first_fit_free_run_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_free_run_unit: first-fit free-run search over a bitmap
// Keeps an 8 x 1024 occupancy map in a 64-bit word memory; marks slot ranges
// busy, clears the map and finds the first run of free slots in one row.
//
//  Channel  Direction  Word contents
//  req_     in         tuser: kind; tdata: row, first_slot, last_slot
//  rsp_     out        tuser: found; tdata: run_row, run_start, run_end
//  csr_     in         run_length, written with csr_wr_en
//
// Search: one memory word read per cycle, up to 128 reads, then the scan
// pipeline and the response; it stops at the word that completes the run.
// Mark: each word touched is read, then written back; 1 to 16 words.
// Clear: per-word valid bits clear at once, no clearing pass.
// Reset is synchronous; a result held on rsp_ does not stop marks or clears.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_free_run_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // slave side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // row[2:0], first_slot[12:3], last_slot[22:13]
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   // master side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // run_row[2:0], run_start[12:3], run_end[22:13]
   output logic [0:0]       rsp_tuser,   // found[0]
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // request fields
   logic [1:0]                      req_kind;
   logic [bffr_pkg::ROW_W-1:0]      req_row;
   logic [bffr_pkg::SLOT_W-1:0]     req_first;
   logic [bffr_pkg::SLOT_W-1:0]     req_last;
   logic [bffr_pkg::SLOT_W-1:0]     last_clamp;
   logic                            mark_ok;
   logic                            req_acc;

   // registers
   state_type                       state_ff, state_in;
   logic [bffr_pkg::CNT_W-1:0]      run_len_ff;
   logic [bffr_pkg::ROW_W-1:0]      mk_row_ff, mk_row_in;
   logic [bffr_pkg::WIDX_W-1:0]     mk_word_ff, mk_word_in;
   logic [bffr_pkg::WIDX_W-1:0]     mk_wlast_ff, mk_wlast_in;
   logic [bffr_pkg::BIT_W-1:0]      mk_lbit_ff, mk_lbit_in;
   logic [bffr_pkg::WORD_BITS-1:0]  mk_lo_ff, mk_lo_in;
   logic [bffr_pkg::ADDR_W-1:0]     sr_addr_ff, sr_addr_in;
   logic                            sr_issue_ff, sr_issue_in;
   logic                            a_vld_ff, a_vld_in;
   logic [bffr_pkg::ADDR_W-1:0]     a_addr_ff;
   bffr_pkg::scan_res_type          hold_ff, hold_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bffr_pkg::scan_res_type          rsp_ff, rsp_in;

   // memory and scan hookup
   logic                            ram_rd_en;
   logic [bffr_pkg::ADDR_W-1:0]     ram_rd_addr;
   logic [bffr_pkg::WORD_BITS-1:0]  ram_rd_data;
   logic                            ram_wr_en;
   logic [bffr_pkg::WORD_BITS-1:0]  ram_wr_data;
   logic                            ram_clear;
   logic [bffr_pkg::WORD_BITS-1:0]  hi_mask;
   logic [bffr_pkg::CNT_W-1:0]      need;
   logic                            flush;
   bffr_pkg::scan_in_type           scan_in;
   bffr_pkg::scan_res_type          res;

   // field unpacking
   assign req_kind  = req_tuser;
   assign req_row   = req_tdata[2:0];
   assign req_first = req_tdata[12:3];
   assign req_last  = req_tdata[22:13];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // mark range checks with the end clamped to the row
   always_comb begin
      last_clamp = (32'(req_last) > bffr_pkg::SLOTS - 1) ? bffr_pkg::SLOT_MAX : req_last;
      mark_ok    = (32'(req_row) < bffr_pkg::ROWS) && (32'(req_first) < bffr_pkg::SLOTS)
                   && (req_first <= last_clamp);
   end

   // zero run length counts as one
   assign need = (run_len_ff == '0) ? bffr_pkg::CNT_W'(1) : run_len_ff;

   // busy mask of the word being marked
   assign hi_mask = (mk_word_ff == mk_wlast_ff) ? ('1 >> (~mk_lbit_ff)) : '1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mk_row_in    = mk_row_ff;
      mk_word_in   = mk_word_ff;
      mk_wlast_in  = mk_wlast_ff;
      mk_lbit_in   = mk_lbit_ff;
      mk_lo_in     = mk_lo_ff;
      sr_addr_in   = sr_addr_ff;
      sr_issue_in  = 1'b0;
      a_vld_in     = 1'b0;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = sr_addr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = ram_rd_data & ~(mk_lo_ff & hi_mask);
      ram_clear    = 1'b0;
      flush        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_kind)
                  bffr_pkg::KIND_MARK: begin
                     mk_row_in   = req_row;
                     mk_word_in  = req_first[bffr_pkg::SLOT_W-1:bffr_pkg::BIT_W];
                     mk_wlast_in = last_clamp[bffr_pkg::SLOT_W-1:bffr_pkg::BIT_W];
                     mk_lbit_in  = last_clamp[bffr_pkg::BIT_W-1:0];
                     mk_lo_in    = '1 << req_first[bffr_pkg::BIT_W-1:0];
                     if (mark_ok) begin
                        state_in = ST_MARK_RD;
                     end
                  end
                  bffr_pkg::KIND_SEARCH: begin
                     sr_addr_in  = '0;
                     sr_issue_in = 1'b1;
                     state_in    = ST_SEARCH;
                  end
                  bffr_pkg::KIND_CLEAR: begin
                     ram_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MARK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = {mk_row_ff, mk_word_ff};
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            ram_wr_en = 1'b1;
            mk_lo_in  = '1;
            if (mk_word_ff == mk_wlast_ff) begin
               state_in = ST_IDLE;
            end else begin
               mk_word_in = mk_word_ff + 1'b1;
               state_in   = ST_MARK_RD;
            end
         end
         ST_SEARCH: begin
            if (res.done) begin
               flush    = 1'b1;
               hold_in  = res;
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = sr_issue_ff;
               a_vld_in    = sr_issue_ff;
               sr_addr_in  = sr_addr_ff + 1'b1;
               sr_issue_in = sr_issue_ff && (sr_addr_ff != '1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_len_ff   <= bffr_pkg::RUN_LEN_RESET;
         sr_issue_ff  <= 1'b0;
         a_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sr_issue_ff  <= sr_issue_in;
         a_vld_ff     <= a_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            run_len_ff <= csr_wr_data;
         end
      end
      mk_row_ff   <= mk_row_in;
      mk_word_ff  <= mk_word_in;
      mk_wlast_ff <= mk_wlast_in;
      mk_lbit_ff  <= mk_lbit_in;
      mk_lo_ff    <= mk_lo_in;
      sr_addr_ff  <= sr_addr_in;
      a_addr_ff   <= sr_addr_ff;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
   end

   // word leaving the memory toward the scan
   always_comb begin
      scan_in.vld  = a_vld_ff && !flush;
      scan_in.last = (a_addr_ff == '1);
      scan_in.row  = a_addr_ff[bffr_pkg::ADDR_W-1:bffr_pkg::WIDX_W];
      scan_in.widx = a_addr_ff[bffr_pkg::WIDX_W-1:0];
   end

   bffr_map_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .clear_all (ram_clear),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data   (ram_rd_data),
      .wr_en     (ram_wr_en),
      .wr_addr   ({mk_row_ff, mk_word_ff}),
      .wr_data   (ram_wr_data)
   );

   bffr_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .flush   (flush),
      .scan_in (scan_in),
      .word    (ram_rd_data),
      .need    (need),
      .res     (res)
   );

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.run_end, rsp_ff.run_start, rsp_ff.run_row};
   assign rsp_tuser  = rsp_ff.found;

   // scan finishes only while a search runs
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      res.done |-> (state_ff == ST_SEARCH))
      else $error("scan result outside a search");

   // map is written only in the write-back step of a mark
   a_wr_in_mark: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_MARK_WR))
      else $error("map write outside a mark");

   // read and write never share a cycle
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("map read and write in one cycle");

   // a found run spans exactly the needed length
   a_run_span: assert property (@(posedge clock) disable iff (reset)
      (res.done && res.found) |->
         ((res.run_end - res.run_start) == bffr_pkg::SLOT_W'(need - bffr_pkg::CNT_W'(1))))
      else $error("run span differs from run length");

   // a result leaves the scan only into an empty hold step
   a_done_to_hold: assert property (@(posedge clock) disable iff (reset)
      (res.done && state_ff == ST_SEARCH) |=> (state_ff == ST_DONE))
      else $error("search result not captured");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bitmap_first_fit_free_run_unit
// Drives mark, search and clear words on the request stream and keeps its own
// copy of the occupancy map. Each search word yields a predicted run that is
// compared field by field with the response stream. The run length register
// is swept across its extremes while the block is idle. Both streams idle and
// stall at random, and one phase holds the response side off for a long time.
// ----------------------------------------------------------------------------
module testbench;

   localparam int         ROWS          = bffr_pkg::ROWS;
   localparam int         SLOTS         = bffr_pkg::SLOTS;
   localparam int         ROW_W         = bffr_pkg::ROW_W;
   localparam int         SLOT_W        = bffr_pkg::SLOT_W;
   localparam int         CNT_W         = bffr_pkg::CNT_W;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         WORD_TARGET   = 1950;
   localparam int         SETTLE_CYCLES = 40;    // longest mark: 16 words, each read and written back
   localparam int         END_CYCLES    = 150;   // longest search plus response
   localparam int         PRINT_CAP     = 50;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ROW_W-1:0]  row;
      logic [SLOT_W-1:0] first_slot;
      logic [SLOT_W-1:0] last_slot;
   } req_word_type;

   typedef struct packed {
      logic              found;
      logic [ROW_W-1:0]  run_row;
      logic [SLOT_W-1:0] run_start;
      logic [SLOT_W-1:0] run_end;
   } free_run_type;

   // DUT signals, every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // row[2:0], first_slot[12:3], last_slot[22:13]
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // run_row[2:0], run_start[12:3], run_end[22:13]
   logic [0:0]  rsp_tuser;        // found[0]
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   // predictor state: one bit per slot, 1 = free
   logic [SLOTS-1:0] free_rows [ROWS];
   logic [CNT_W-1:0] run_len_q;
   free_run_type     expected_runs [$];

   // bookkeeping
   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  words_counted   = 0;
   int  marks_sent      = 0;
   int  searches_sent   = 0;
   int  clears_sent     = 0;
   int  ignored_sent    = 0;
   int  length_writes   = 0;
   int  rsp_hold_req    = 0;
   bit  steady          = 1'b0;

   bitmap_first_fit_free_run_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #30_000_000;
      $display("timeout: %0d runs still expected", expected_runs.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void free_all_slots();
      foreach (free_rows[r]) free_rows[r] = '1;
   endfunction

   function automatic void mark_range_busy(input req_word_type w);
      int lo, hi;
      lo = int'(w.first_slot);
      hi = int'(w.last_slot);
      if (int'(w.row) >= ROWS || lo >= SLOTS) return;
      if (hi > SLOTS - 1) hi = SLOTS - 1;
      for (int s = lo; s <= hi; s++) free_rows[w.row][s] = 1'b0;
   endfunction

   // first run of run_len_q free slots, rows in order, slots in order
   function automatic free_run_type find_first_run();
      free_run_type res;
      int need, count;
      res = '0;
      need = (run_len_q == 0) ? 1 : int'(run_len_q);
      for (int r = 0; r < ROWS; r++) begin
         count = 0;
         for (int s = 0; s < SLOTS; s++) begin
            count = free_rows[r][s] ? count + 1 : 0;
            if (count >= need) begin
               res.found     = 1'b1;
               res.run_row   = ROW_W'(r);
               res.run_start = SLOT_W'(s + 1 - need);
               res.run_end   = SLOT_W'(s);
               return res;
            end
         end
      end
      return res;
   endfunction

   // apply one accepted word to the map and queue any predicted run
   function automatic void apply_word(input req_word_type w);
      case (w.kind)
         bffr_pkg::KIND_MARK: begin
            mark_range_busy(w);
            if (w.first_slot <= w.last_slot) begin
               marks_sent++;
               words_counted++;
            end else begin
               ignored_sent++;
            end
         end
         bffr_pkg::KIND_SEARCH: begin
            expected_runs.push_back(find_first_run());
            searches_sent++;
            words_counted++;
         end
         bffr_pkg::KIND_CLEAR: begin
            free_all_slots();
            clears_sent++;
            words_counted++;
         end
         default: begin
            ignored_sent++;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      // cap the log on a badly broken block; the count keeps going
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at result %0d: %s got %0d, want %0d",
                  results_checked, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_check
      free_run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_runs.size() == 0) begin
            report_mismatch("unexpected word, found", rsp_tuser[0], 0);
         end else begin
            want = expected_runs.pop_front();
            if (rsp_tuser[0] !== want.found)
               report_mismatch("found", rsp_tuser[0], want.found);
            if (rsp_tdata[ROW_W-1:0] !== want.run_row)
               report_mismatch("run_row", rsp_tdata[ROW_W-1:0], want.run_row);
            if (rsp_tdata[ROW_W +: SLOT_W] !== want.run_start)
               report_mismatch("run_start", rsp_tdata[ROW_W +: SLOT_W], want.run_start);
            if (rsp_tdata[ROW_W+SLOT_W +: SLOT_W] !== want.run_end)
               report_mismatch("run_end", rsp_tdata[ROW_W+SLOT_W +: SLOT_W],
                               want.run_end);
         end
         results_checked++;
      end
   end

   // response ready: random stalls, long hold-off on request
   initial begin : rsp_ready_gen
      int hold_len;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_len = rsp_hold_req;
            rsp_hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold_len) @(negedge clock);
         end else if (steady || $urandom_range(0, 9) < 7) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            hold_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3);
            repeat (hold_len - 1) @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type random_word(input logic [1:0] kind);
      req_word_type w;
      w.kind       = kind;
      w.row        = ROW_W'($urandom);
      w.first_slot = SLOT_W'($urandom);
      w.last_slot  = SLOT_W'($urandom);
      return w;
   endfunction

   // well-formed mark, weighted toward short ranges in the first rows
   function automatic req_word_type random_mark();
      req_word_type w;
      int width, lo, hi, p;
      w = random_word(bffr_pkg::KIND_MARK);
      if ($urandom_range(0, 99) < 60) w.row = ROW_W'($urandom_range(0, 2));
      p = $urandom_range(0, 99);
      if (p < 60)      width = $urandom_range(1, 16);
      else if (p < 90) width = $urandom_range(17, 300);
      else if (p < 97) width = $urandom_range(301, SLOTS);
      else             width = SLOTS;
      lo = (width == SLOTS) ? 0 : $urandom_range(0, SLOTS - 1);
      hi = lo + width - 1;
      if (hi > SLOTS - 1) hi = SLOTS - 1;
      w.first_slot = SLOT_W'(lo);
      w.last_slot  = SLOT_W'(hi);
      return w;
   endfunction

   function automatic req_word_type make_mark(input int row, input int lo, input int hi);
      req_word_type w;
      w = random_word(bffr_pkg::KIND_MARK);
      w.row        = ROW_W'(row);
      w.first_slot = SLOT_W'(lo);
      w.last_slot  = SLOT_W'(hi);
      return w;
   endfunction

   function automatic logic [CNT_W-1:0] random_run_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 5)  return '0;
      if (p < 40) return CNT_W'($urandom_range(1, 16));
      if (p < 70) return CNT_W'($urandom_range(17, 128));
      if (p < 90) return CNT_W'($urandom_range(129, SLOTS));
      if (p < 95) return CNT_W'($urandom_range(SLOTS + 1, 2047));
      return CNT_W'(SLOTS);
   endfunction

   // offer one word after a gap; returns once it is accepted
   task automatic send_word(input req_word_type w, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tdata  <= {1'b0, w.last_slot, w.first_slot, w.row};
      do @(posedge clock); while (!req_tready);
      apply_word(w);
   endtask

   task automatic drain_results();
      while (expected_runs.size() != 0) @(posedge clock);
   endtask

   // stop offering, let every result and any trailing mark finish
   task automatic quiesce(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      drain_results();
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_run_length(input logic [CNT_W-1:0] value);
      quiesce(SETTLE_CYCLES);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      run_len_q = value;
      length_writes++;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // boundaries at the reset run length of 60
   task automatic test_directed();
      send_word(random_word(bffr_pkg::KIND_SEARCH), 0);          // empty map
      send_word(make_mark(0, 0, 0), pick_gap());
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      send_word(make_mark(0, 30, 30), pick_gap());
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      send_word(make_mark(0, 0, SLOTS - 1), pick_gap()); // whole row busy
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      send_word(make_mark(1, 500, 400), pick_gap());     // reversed range
      send_word(make_mark(1, 60, SLOTS - 1), pick_gap()); // run exactly fits
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      send_word(make_mark(1, 59, 59), pick_gap());
      send_word('{kind: KIND_UNUSED, row: '1, first_slot: '1, last_slot: '1}, 0);
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      for (int r = 2; r < ROWS; r++) send_word(make_mark(r, 0, SLOTS - 1), pick_gap());
      send_word(make_mark(ROWS - 1, SLOTS - 1, SLOTS - 1), 0);
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());   // full map, nothing found
      send_word(random_word(bffr_pkg::KIND_CLEAR), pick_gap());
      send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
   endtask

   // run length register at its extremes, including zero and longer than a row
   task automatic test_run_lengths();
      logic [CNT_W-1:0] lengths [8];
      lengths = '{CNT_W'(0), CNT_W'(1), CNT_W'(2), CNT_W'(60),
                  CNT_W'(SLOTS - 1), CNT_W'(SLOTS), CNT_W'(SLOTS + 1), CNT_W'(2047)};
      foreach (lengths[i]) begin
         write_run_length(lengths[i]);
         send_word(random_word(bffr_pkg::KIND_CLEAR), pick_gap());
         send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
         send_word(make_mark(0, $urandom_range(0, 3), $urandom_range(3, 6)), pick_gap());
         send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
         send_word(make_mark(0, 0, SLOTS - 1), pick_gap());
         send_word(make_mark(1, SLOTS - 1, SLOTS - 1), pick_gap());
         send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      end
   endtask

   // long response hold-off while requests keep coming, then a full drain
   task automatic test_back_pressure();
      write_run_length(CNT_W'($urandom_range(1, 8)));
      send_word(random_word(bffr_pkg::KIND_CLEAR), 0);
      rsp_hold_req = 800;
      repeat (40) begin
         if ($urandom_range(0, 1) == 0) send_word(random_mark(), 0);
         else                           send_word(random_word(bffr_pkg::KIND_SEARCH), 0);
      end
      quiesce(0);
   endtask

   // no idling on either side
   task automatic test_steady_flow();
      steady = 1'b1;
      send_word(random_word(bffr_pkg::KIND_CLEAR), 0);
      repeat (100) begin
         if ($urandom_range(0, 2) == 0) send_word(random_word(bffr_pkg::KIND_SEARCH), 0);
         else                           send_word(random_mark(), 0);
      end
      steady = 1'b0;
   endtask

   // episodes: optional new length, clear, marks and searches, a few odd words
   task automatic test_random_episodes();
      int n, p;
      while (words_counted < WORD_TARGET) begin
         if ($urandom_range(0, 3) == 0) write_run_length(random_run_length());
         if ($urandom_range(0, 9) != 0)
            send_word(random_word(bffr_pkg::KIND_CLEAR), pick_gap());
         n = $urandom_range(4, 30);
         repeat (n) begin
            p = $urandom_range(0, 99);
            if (p < 62)      send_word(random_mark(), pick_gap());
            else if (p < 92) send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
            else if (p < 94) send_word(random_word(bffr_pkg::KIND_CLEAR), pick_gap());
            else if (p < 97) send_word(random_word(KIND_UNUSED), pick_gap());
            else             send_word(make_mark($urandom_range(0, ROWS - 1),
                                                 $urandom_range(1, SLOTS - 1), 0),
                                       pick_gap());
         end
         send_word(random_word(bffr_pkg::KIND_SEARCH), pick_gap());
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      free_all_slots();
      run_len_q = bffr_pkg::RUN_LEN_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_run_lengths();
      test_back_pressure();
      test_steady_flow();
      test_random_episodes();
      quiesce(END_CYCLES);

      if (expected_runs.size() != 0)
         report_mismatch("leftover expected runs", expected_runs.size(), 0);
      $display("covered %0d words: %0d marks, %0d searches, %0d clears, %0d ignored",
               words_counted + ignored_sent, marks_sent, searches_sent, clears_sent,
               ignored_sent);
      $display("checked %0d results over %0d run length settings, %0d mismatches",
               results_checked, length_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/bffr_pkg.sv
src/bffr_map_ram.sv
src/bffr_scan.sv
src/bitmap_first_fit_free_run_unit.sv
tb/sv/testbench.sv
